// ===== hw/rtl/ordered_slot_list_with_index_notify_macros.svh =====
// assertion macros for the ordered slot list checker
`ifndef ORDERED_SLOT_LIST_WITH_INDEX_NOTIFY_MACROS_SVH
`define ORDERED_SLOT_LIST_WITH_INDEX_NOTIFY_MACROS_SVH

// same-cycle implication, off during reset
`define OSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered slot list check failed");

// next-cycle implication, off during reset
`define OSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered slot list check failed");

// next-cycle implication, always on
`define OSL_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ordered slot list reset check failed");

`endif

// ===== hw/rtl/osl_pkg.sv =====
// shared types and codes for the ordered slot list
`default_nettype none
package osl_pkg;

  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_MOVE   = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_HANDLE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_INPUT,
    SRC_HELD
  } src_t;

  typedef struct packed {
    logic             need_held;
    logic             shift_dn;
    logic [IDX_W-1:0] shift_n;
    logic [IDX_W-1:0] start;
    logic [1:0]       fin_kind;
    src_t             fin_src;
    logic             fin_write;
    logic [IDX_W-1:0] fin_slot;
    logic [CNT_W-1:0] count_after;
  } op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/osl_front.sv =====
// command intake: range checks, count tracking and operation setup
`default_nettype none
module osl_front #(
  parameter int DEPTH       = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             cmd,
  input  logic [5:0]             position,
  input  logic [4:0]             dest_position,
  input  logic [HANDLE_BITS-1:0] handle_in,
  input  logic                   q_full,
  output logic                   q_push,
  output osl_pkg::op_t           q_op,
  output logic [HANDLE_BITS-1:0] q_handle
);
  import osl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [31:0]   pos_w;
  logic [31:0]   dst_w;
  logic [31:0]   cnt_w;
  op_t           op;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_handle = handle_in;
  assign q_op     = op;

  always_comb begin
    pos_w      = 32'(position);
    dst_w      = 32'(dest_position);
    cnt_w      = 32'(count);
    op         = '0;
    op.fin_kind = KIND_ERROR;
    op.fin_src  = SRC_ZERO;
    count_next = count;
    unique case (cmd)
      CMD_INSERT: begin
        if (cnt_w < 32'(DEPTH) && pos_w <= cnt_w) begin
          op.shift_dn  = 1'b0;
          op.shift_n   = IDX_W'(cnt_w - pos_w);
          op.start     = IDX_W'(cnt_w);
          op.fin_kind  = KIND_UPDATE;
          op.fin_src   = SRC_INPUT;
          op.fin_write = 1'b1;
          op.fin_slot  = IDX_W'(pos_w);
          count_next   = count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_w < cnt_w) begin
          op.need_held = 1'b1;
          op.shift_dn  = 1'b1;
          op.shift_n   = IDX_W'(cnt_w - pos_w - 32'd1);
          op.start     = IDX_W'(pos_w);
          op.fin_kind  = KIND_HANDLE;
          op.fin_src   = SRC_HELD;
          count_next   = count - 1'b1;
        end
      end
      CMD_MOVE: begin
        if (pos_w < cnt_w && dst_w < cnt_w) begin
          if (pos_w == dst_w) begin
            op.fin_kind = KIND_DONE;
          end else begin
            op.need_held = 1'b1;
            op.shift_dn  = pos_w < dst_w;
            op.shift_n   = (pos_w < dst_w) ? IDX_W'(dst_w - pos_w) : IDX_W'(pos_w - dst_w);
            op.start     = IDX_W'(pos_w);
            op.fin_kind  = KIND_UPDATE;
            op.fin_src   = SRC_HELD;
            op.fin_write = 1'b1;
            op.fin_slot  = IDX_W'(dst_w);
          end
        end
      end
      CMD_READ: begin
        if (pos_w < cnt_w) begin
          op.need_held = 1'b1;
          op.start     = IDX_W'(pos_w);
          op.fin_kind  = KIND_HANDLE;
          op.fin_src   = SRC_HELD;
        end
      end
      CMD_CLEAR: begin
        op.fin_kind = KIND_DONE;
        count_next  = '0;
      end
      default: begin
        op.fin_kind = KIND_ERROR;
      end
    endcase
    op.count_after = CNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/osl_fifo.sv =====
// two-entry queue between intake and execution
`default_nettype none
module osl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] store [2];
  logic             wp;
  logic             rp;
  logic [1:0]       used;

  assign full     = (used == 2'd2);
  assign rd_valid = (used != 2'd0);
  assign rd_data  = store[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      used <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/osl_back.sv =====
// execution: slot memory, shift sequencer and result register
`default_nettype none
module osl_back #(
  parameter int DEPTH       = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  osl_pkg::op_t           q_op,
  input  logic [HANDLE_BITS-1:0] q_handle,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             kind,
  output logic [HANDLE_BITS-1:0] handle_out,
  output logic [4:0]             slot,
  output logic [5:0]             count_out,
  output logic                   last
);
  import osl_pkg::*;

  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HELD,
    S_SHIFT,
    S_FINAL
  } state_t;

  state_t                 state;
  op_t                    op;
  logic [HANDLE_BITS-1:0] hin;
  logic [HANDLE_BITS-1:0] held;
  logic [HANDLE_BITS-1:0] rdata;
  logic [HANDLE_BITS-1:0] slots [DEPTH];
  logic [IW-1:0]          wi;
  logic [IW-1:0]          left;
  logic                   ren;
  logic [IW-1:0]          raddr;
  logic                   wen;
  logic [IW-1:0]          waddr;
  logic [HANDLE_BITS-1:0] wdata;
  logic                   advance;
  logic [HANDLE_BITS-1:0] fin_handle;

  assign advance = !out_valid || !out_stall;
  assign q_pop   = (state == S_IDLE) && q_valid;

  always_comb begin
    case (op.fin_src)
      SRC_INPUT: fin_handle = hin;
      SRC_HELD:  fin_handle = held;
      default:   fin_handle = '0;
    endcase
  end

  always_comb begin
    ren   = 1'b0;
    raddr = wi;
    wen   = 1'b0;
    waddr = wi;
    wdata = rdata;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_op.need_held) begin
            ren   = 1'b1;
            raddr = IW'(q_op.start);
          end else if (q_op.shift_n != '0) begin
            ren   = 1'b1;
            raddr = q_op.shift_dn ? IW'(q_op.start) + IW'(1) : IW'(q_op.start) - IW'(1);
          end
        end
      end
      S_HELD: begin
        if (left != '0) begin
          ren   = 1'b1;
          raddr = op.shift_dn ? wi + IW'(1) : wi - IW'(1);
        end
      end
      S_SHIFT: begin
        if (advance) begin
          wen = 1'b1;
          if (left > IW'(1)) begin
            ren   = 1'b1;
            raddr = op.shift_dn ? wi + IW'(2) : wi - IW'(2);
          end
        end
      end
      S_FINAL: begin
        if (advance && op.fin_write) begin
          wen   = 1'b1;
          waddr = IW'(op.fin_slot);
          wdata = fin_handle;
        end
      end
      default: begin
        ren = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      slots[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= slots[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (advance) begin
            out_valid <= 1'b0;
          end
          if (q_valid) begin
            op   <= q_op;
            hin  <= q_handle;
            wi   <= IW'(q_op.start);
            left <= IW'(q_op.shift_n);
            if (q_op.need_held) begin
              state <= S_HELD;
            end else if (q_op.shift_n != '0) begin
              state <= S_SHIFT;
            end else begin
              state <= S_FINAL;
            end
          end
        end
        S_HELD: begin
          if (advance) begin
            out_valid <= 1'b0;
          end
          held  <= rdata;
          state <= (left != '0) ? S_SHIFT : S_FINAL;
        end
        S_SHIFT: begin
          if (advance) begin
            out_valid  <= 1'b1;
            kind       <= KIND_UPDATE;
            handle_out <= rdata;
            slot       <= 5'(wi);
            count_out  <= 6'(op.count_after);
            last       <= 1'b0;
            wi         <= op.shift_dn ? wi + IW'(1) : wi - IW'(1);
            left       <= left - IW'(1);
            if (left == IW'(1)) begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (advance) begin
            out_valid  <= 1'b1;
            kind       <= op.fin_kind;
            handle_out <= fin_handle;
            slot       <= 5'(op.fin_slot);
            count_out  <= 6'(op.count_after);
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ordered_slot_list_with_index_notify.sv =====
// Ordered slot list with index notification.
// Input channel (in_valid / in_stall) takes one command per transaction: insert,
// remove, move, read or clear, with position, dest_position and handle_in.
// Output channel (out_valid / out_stall) returns the results of each command in
// order: one index update per shifted entry, then the final result with last set
// (the placed entry's update, a handle or a status). count_out on every result
// is the list size after the command. The slot memory has one read port and one
// write port; in the execution unit a command that needs its source entry
// fetches it first, then each shifted entry takes one read and one write,
// overlapped across entries, and the final result comes last.
// A two-entry command queue sits between intake and execution, so up to two
// commands are taken while earlier results are still being produced.
// When out_stall is high with out_valid set, the result register and the shift and final steps hold.
// Reset empties the list and the queue; slot contents are not cleared and
// are only read below the current count.
`default_nettype none
module ordered_slot_list_with_index_notify #(
  parameter int DEPTH       = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             cmd,
  input  logic [5:0]             position,
  input  logic [4:0]             dest_position,
  input  logic [HANDLE_BITS-1:0] handle_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             kind,
  output logic [HANDLE_BITS-1:0] handle_out,
  output logic [4:0]             slot,
  output logic [5:0]             count_out,
  output logic                   last
);
  import osl_pkg::*;

  localparam int QW = $bits(op_t) + HANDLE_BITS;

  logic                   f_push;
  op_t                    f_op;
  logic [HANDLE_BITS-1:0] f_handle;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  logic [QW-1:0]          q_data;
  op_t                    b_op;
  logic [HANDLE_BITS-1:0] b_handle;

  assign {b_op, b_handle} = q_data;

  osl_front #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .position      (position),
    .dest_position (dest_position),
    .handle_in     (handle_in),
    .q_full        (q_full),
    .q_push        (f_push),
    .q_op          (f_op),
    .q_handle      (f_handle)
  );

  osl_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .wr_data  ({f_op, f_handle}),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  osl_back #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (b_op),
    .q_handle   (b_handle),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .handle_out (handle_out),
    .slot       (slot),
    .count_out  (count_out),
    .last       (last)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/osl_checker.sv =====
// port-level checks for the ordered slot list, bound to the top level
`default_nettype none
`include "ordered_slot_list_with_index_notify_macros.svh"
module osl_checker #(
  parameter int HANDLE_BITS = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [2:0]             cmd,
  input logic [5:0]             position,
  input logic [4:0]             dest_position,
  input logic [HANDLE_BITS-1:0] handle_in,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [1:0]             kind,
  input logic [HANDLE_BITS-1:0] handle_out,
  input logic [4:0]             slot,
  input logic [5:0]             count_out,
  input logic                   last
);
  import osl_pkg::*;

  logic [HANDLE_BITS+13:0] in_bits;
  logic [HANDLE_BITS+13:0] out_bits;

  assign in_bits  = {cmd, position, dest_position, handle_in};
  assign out_bits = {kind, handle_out, slot, count_out, last};

  // stalled command transaction holds
  `OSL_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_bits))
  // stalled result transaction holds
  `OSL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bits))
  `OSL_ASSERT_RESET(a_reset_empty, rst, !out_valid)
  `OSL_ASSERT_NOW(a_status_zero, out_valid && (kind == KIND_ERROR || kind == KIND_DONE), handle_out == '0 && slot == 5'd0)
  `OSL_ASSERT_NOW(a_mid_is_update, out_valid && !last, kind == KIND_UPDATE)

endmodule

bind ordered_slot_list_with_index_notify osl_checker #(
  .HANDLE_BITS (HANDLE_BITS)
) u_osl_checker (.*);
`default_nettype wire
